/* rtl/core/lpdalarm_pkg.sv */
package lpdalarm_pkg;

  // Configuration register map
  typedef enum logic [1:0] {
    REG_WINDOW_LEN = 2'd0,
    REG_GAIN_Q16   = 2'd1,
    REG_THRESHOLD  = 2'd2,
    REG_BUZZ_INT   = 2'd3
  } cfg_reg_t;

  // Input request kinds
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_kind_t;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned WLEN_W      = 11;
  localparam int unsigned GAIN_W      = 24;
  localparam int unsigned CUR_W       = 16;
  localparam int unsigned MS_W        = 16;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned FRAC_BITS   = 16;

  localparam logic [WLEN_W-1:0] WLEN_RST   = 11'd256;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 24'd65536;
  localparam logic [CUR_W-1:0]  THRESH_RST = 16'd300;
  localparam logic [MS_W-1:0]   BUZZ_RST   = 16'd500;

  localparam logic [CUR_W-1:0]  MIN_READING = 16'd20;
  localparam logic [CUR_W-1:0]  CURRENT_MAX = 16'hFFFF;
  localparam logic [MS_W-1:0]   MS_MAX      = 16'hFFFF;

endpackage

/* rtl/core/leakage_peak_detector_alarm_core.sv */
// Leakage peak-to-peak detector with alarm outputs.
//
// Input channel (in_valid/in_ready): each request is either an ADC sample
// (in_req_type = 0, in_sample holds the raw code) or a 1 ms tick
// (in_req_type = 1, in_sample ignored). Every request yields exactly one
// result request on the out_ channel carrying the window-done flag, the
// latest current in 0.1 mA, alert, relay/LED drive and buzzer pin level.
// Config (cfg_wr_en/cfg_index/cfg_data) is write-only; write only while
// the block is drained.
//
// A request accepted into the input register moves on to the result
// register, whose output is out_valid. One request per cycle is sustained
// while out_ready stays high; the single multiply of peak-to-peak by gain
// sits between the two registers. in_ready drops only when both the input
// register and the result register hold requests and out_ready is low; a
// stalled receiver therefore backs up two deep and then stalls the sender.
//
// Reset (synchronous, rst_n low): pipeline empty, config back to defaults
// (window 256, gain 1.0, threshold 30.0 mA, buzzer 500 ms), window
// min/max cleared, alert and buzzer off, ms counter saturated.
module leakage_peak_detector_alarm_core
  import lpdalarm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 1024,
  parameter int unsigned ADC_BITS   = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input requests
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_req_type,
  input  logic [SAMPLE_W-1:0]    in_sample,
  // result requests
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_measurement_done,
  output logic [CUR_W-1:0]       out_current_tenth_ma,
  output logic                   out_alert,
  output logic                   out_relay_open,
  output logic                   out_led_on,
  output logic                   out_buzzer_on,
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PROD_W = ADC_BITS + GAIN_W;
  localparam int unsigned SH_W   = PROD_W + 1 - FRAC_BITS;
  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};
  localparam logic [CNT_W-1:0]    MAX_WIN_C = CNT_W'(MAX_WINDOW);
  localparam logic [PROD_W:0]     ROUND_C = (PROD_W+1)'(1) << (FRAC_BITS - 1);

  // config registers
  logic [WLEN_W-1:0] wlen_r;
  logic [GAIN_W-1:0] gain_r;
  logic [CUR_W-1:0]  thresh_r;
  logic [MS_W-1:0]   buzz_int_r;

  // input register
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_req_r;
  logic [ADC_BITS-1:0] s1_sample_r;

  // result register / block state
  logic                out_valid_r, out_valid_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADC_BITS-1:0] win_min_r, win_min_nxt;
  logic [ADC_BITS-1:0] win_max_r, win_max_nxt;
  logic [CUR_W-1:0]    cur_r, cur_nxt;
  logic                alert_r, alert_nxt;
  logic                phase_r, phase_nxt;
  logic                level_r, level_nxt;
  logic [MS_W-1:0]     ms_r, ms_nxt;

  logic                advance;
  logic                in_take;
  logic [CNT_W-1:0]    eff_len;
  logic [CNT_W-1:0]    count_inc;
  logic [ADC_BITS-1:0] smin, smax, p2p;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     prod_rnd;
  logic [SH_W-1:0]     scaled;
  logic [CUR_W-1:0]    reading;

  // handshake: result register frees up when empty or being taken
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  // effective window length: zero acts as one, clamp to MAX_WINDOW
  always_comb begin
    if (wlen_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(wlen_r) > 32'(MAX_WINDOW)) begin
      eff_len = MAX_WIN_C;
    end else begin
      eff_len = CNT_W'(wlen_r);
    end
  end

  assign count_inc = count_r + CNT_W'(1);
  assign smin = (s1_sample_r < win_min_r) ? s1_sample_r : win_min_r;
  assign smax = (s1_sample_r > win_max_r) ? s1_sample_r : win_max_r;
  assign p2p  = smax - smin;

  // Q8.16 scaling, round half up, saturate, squelch below 2 mA
  assign prod     = PROD_W'(p2p) * PROD_W'(gain_r);
  assign prod_rnd = (PROD_W+1)'(prod) + ROUND_C;
  assign scaled   = prod_rnd[PROD_W:FRAC_BITS];

  always_comb begin
    if (|scaled[SH_W-1:CUR_W]) begin
      reading = CURRENT_MAX;
    end else if (scaled[CUR_W-1:0] < MIN_READING) begin
      reading = '0;
    end else begin
      reading = scaled[CUR_W-1:0];
    end
  end

  always_comb begin
    done_nxt    = done_r;
    count_nxt   = count_r;
    win_min_nxt = win_min_r;
    win_max_nxt = win_max_r;
    cur_nxt     = cur_r;
    alert_nxt   = alert_r;
    phase_nxt   = phase_r;
    level_nxt   = level_r;
    ms_nxt      = ms_r;
    if (advance && s1_valid_r) begin
      done_nxt = 1'b0;
      if (s1_req_r == REQ_TICK) begin
        if (ms_r != MS_MAX) begin
          ms_nxt = ms_r + MS_W'(1);
        end
      end else if (count_inc >= eff_len) begin
        // window closes
        done_nxt    = 1'b1;
        count_nxt   = '0;
        win_min_nxt = ADC_MAX;
        win_max_nxt = '0;
        cur_nxt     = reading;
        alert_nxt   = (reading >= thresh_r);
        if (reading >= thresh_r) begin
          if (ms_r >= buzz_int_r) begin
            phase_nxt = !phase_r;
            ms_nxt    = '0;
            level_nxt = !phase_r;
          end else begin
            level_nxt = phase_r;
          end
        end else begin
          level_nxt = 1'b0;
        end
      end else begin
        count_nxt   = count_inc;
        win_min_nxt = smin;
        win_max_nxt = smax;
      end
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r     <= WLEN_RST;
      gain_r     <= GAIN_RST;
      thresh_r   <= THRESH_RST;
      buzz_int_r <= BUZZ_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LEN: wlen_r     <= cfg_data[WLEN_W-1:0];
        REG_GAIN_Q16:   gain_r     <= cfg_data[GAIN_W-1:0];
        REG_THRESHOLD:  thresh_r   <= cfg_data[CUR_W-1:0];
        REG_BUZZ_INT:   buzz_int_r <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r    <= in_req_type;
      s1_sample_r <= ADC_BITS'(in_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
      count_r     <= '0;
      win_min_r   <= ADC_MAX;
      win_max_r   <= '0;
      cur_r       <= '0;
      alert_r     <= 1'b0;
      phase_r     <= 1'b0;
      level_r     <= 1'b0;
      ms_r        <= MS_MAX;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
      count_r     <= count_nxt;
      win_min_r   <= win_min_nxt;
      win_max_r   <= win_max_nxt;
      cur_r       <= cur_nxt;
      alert_r     <= alert_nxt;
      phase_r     <= phase_nxt;
      level_r     <= level_nxt;
      ms_r        <= ms_nxt;
    end
  end

  // state only moves when the result register loads, so it is the result
  assign out_valid            = out_valid_r;
  assign out_measurement_done = done_r;
  assign out_current_tenth_ma = cur_r;
  assign out_alert            = alert_r;
  assign out_relay_open       = alert_r;
  assign out_led_on           = alert_r;
  assign out_buzzer_on        = level_r;

  // window state is cleared on every reported window close
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> count_r == '0 && win_max_r == '0 && win_min_r == ADC_MAX)
    else $error("window state not cleared after close");

  // buzzer can only sound during an alert
  a_buzz_alert: assert property (@(posedge clk) disable iff (!rst_n)
    level_r |-> alert_r)
    else $error("buzzer on without alert");

  // sample counter stays below MAX_WINDOW
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) < 32'(MAX_WINDOW))
    else $error("sample counter out of range");

  // full pipeline with stalled receiver must hold off the sender
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline full");

endmodule

/* bench/tb_leakage_peak_detector_alarm_core.sv */
module tb_leakage_peak_detector_alarm_core;
  import lpdalarm_pkg::*;

  // Block parameters as instantiated below
  localparam int unsigned MAX_WIN       = 1024;
  localparam int unsigned ADC_W         = 12;
  // Window length used by the long window test
  localparam int unsigned LONG_WIN      = 256;
  // Cycles the receiver holds off in the backpressure test
  localparam int unsigned HOLD_CYCLES   = 200;
  // Pipeline is two deep; extra settle time after the queue empties
  localparam int unsigned SETTLE_CYCLES = 4;
  // About 550 requests, plus the hold-off and the drains, taken many times over
  localparam int unsigned LIMIT_CYCLES  = 300000;

  // One result request as it leaves the block
  typedef struct packed {
    logic             done;
    logic [CUR_W-1:0] current;
    logic             alert;
    logic             relay;
    logic             led;
    logic             buzzer;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = 1'b0;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_measurement_done;
  logic [CUR_W-1:0]      out_current_tenth_ma;
  logic                  out_alert;
  logic                  out_relay_open;
  logic                  out_led_on;
  logic                  out_buzzer_on;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register mirror, at reset values
  logic [WLEN_W-1:0]     win_len_reg   = WLEN_RST;
  logic [GAIN_W-1:0]     gain_reg      = GAIN_RST;
  logic [CUR_W-1:0]      thresh_reg    = THRESH_RST;
  logic [MS_W-1:0]       buzz_int_reg  = BUZZ_RST;

  // Detector state mirror, at reset values
  int unsigned           pk_count      = 0;
  logic [SAMPLE_W-1:0]   pk_min        = '1;
  logic [SAMPLE_W-1:0]   pk_max        = '0;
  logic [CUR_W-1:0]      reading_held  = '0;
  logic                  alert_held    = 1'b0;
  logic                  buzz_phase    = 1'b0;
  logic                  buzz_pin      = 1'b0;
  logic [MS_W-1:0]       ms_elapsed    = MS_MAX;

  reading_t              expected_readings[$];
  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count = 0;
  int unsigned           send_idle_pct = 21;
  int unsigned           recv_idle_pct = 57;
  logic                  hold_active = 1'b0;
  logic [SAMPLE_W-1:0]   cluster_base = '0;
  event                  hold_off_trig;

  leakage_peak_detector_alarm_core #(
    .MAX_WINDOW(MAX_WIN),
    .ADC_BITS  (ADC_W)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_measurement_done(out_measurement_done),
    .out_current_tenth_ma(out_current_tenth_ma),
    .out_alert           (out_alert),
    .out_relay_open      (out_relay_open),
    .out_led_on          (out_led_on),
    .out_buzzer_on       (out_buzzer_on),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  // Advances the detector mirror by one request and returns the result the
  // block must produce for it.
  function automatic reading_t predict_reading(req_kind_t kind, logic [SAMPLE_W-1:0] smp);
    reading_t    r;
    logic [63:0] scaled;
    int unsigned eff_len;
    r.done = 1'b0;
    if (kind == REQ_TICK) begin
      // ms counter sticks at all ones, sample field is don't-care
      if (ms_elapsed != MS_MAX) ms_elapsed = ms_elapsed + 1'b1;
    end else begin
      if (smp < pk_min) pk_min = smp;
      if (smp > pk_max) pk_max = smp;
      pk_count++;
      // zero length behaves as one, anything past the max is clamped
      eff_len = (win_len_reg == 0) ? 1 :
                (win_len_reg > MAX_WIN) ? MAX_WIN : int'(win_len_reg);
      // a window shortened under a running count closes right here
      if (pk_count >= eff_len) begin
        // Q16 gain, round half up, saturate, then squelch below 2 mA
        scaled = (64'(pk_max - pk_min) * 64'(gain_reg) + 64'd32768) >> FRAC_BITS;
        if (scaled > 64'(CURRENT_MAX)) reading_held = CURRENT_MAX;
        else if (scaled < 64'(MIN_READING)) reading_held = '0;
        else reading_held = scaled[CUR_W-1:0];
        pk_min   = '1;
        pk_max   = '0;
        pk_count = 0;
        alert_held = (reading_held >= thresh_reg);
        if (alert_held) begin
          // buzzer flips only once the interval has run out; phase survives
          // an alert that clears in between
          if (ms_elapsed >= buzz_int_reg) begin
            buzz_phase = ~buzz_phase;
            ms_elapsed = '0;
          end
          buzz_pin = buzz_phase;
        end else begin
          buzz_pin = 1'b0;
        end
        r.done = 1'b1;
      end
    end
    r.current = reading_held;
    r.alert   = alert_held;
    r.relay   = alert_held;
    r.led     = alert_held;
    r.buzzer  = buzz_pin;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      mismatch_count++;
    end
  endfunction

  // Offers one request, sometimes with a random idle gap in front, and
  // records the expected result once the block takes it. Valid stays high on
  // return so back-to-back requests follow without a gap.
  task automatic send_request(req_kind_t kind, logic [SAMPLE_W-1:0] smp);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_sample   <= smp;
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(predict_reading(kind, smp));
  endtask

  // Drops valid, waits for every outstanding result, then lets the pipe settle.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WINDOW_LEN: win_len_reg  = val[WLEN_W-1:0];
      REG_GAIN_Q16:   gain_reg     = val[GAIN_W-1:0];
      REG_THRESHOLD:  thresh_reg   = val[CUR_W-1:0];
      REG_BUZZ_INT:   buzz_int_reg = val[MS_W-1:0];
      default: ;
    endcase
  endtask

  // Writes are only legal with the pipe empty, so drain first.
  task automatic apply_settings(logic [WLEN_W-1:0] wl, logic [GAIN_W-1:0] gain,
                                logic [CUR_W-1:0] thr, logic [MS_W-1:0] intv);
    drain_pipeline();
    cfg_write(REG_WINDOW_LEN, wl);
    cfg_write(REG_GAIN_Q16, gain);
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_BUZZ_INT, intv);
  endtask

  // Mostly short windows and short buzzer intervals so that window ends,
  // alerts and toggles happen often; now and then the extremes.
  task automatic random_settings();
    logic [WLEN_W-1:0] wl;
    logic [GAIN_W-1:0] gain;
    logic [CUR_W-1:0]  thr;
    logic [MS_W-1:0]   intv;
    wl = ($urandom_range(0, 9) == 0) ? WLEN_W'($urandom_range(17, 64)) :
                                       WLEN_W'($urandom_range(0, 16));
    case ($urandom_range(0, 5))
      0:       gain = GAIN_RST;
      1:       gain = GAIN_W'($urandom_range(16384, 262144));
      2:       gain = GAIN_W'($urandom);
      3:       gain = '0;
      4:       gain = '1;
      default: gain = GAIN_W'($urandom_range(1024, 65536));
    endcase
    case ($urandom_range(0, 4))
      0:       thr = '0;
      1:       thr = '1;
      2:       thr = CUR_W'($urandom);
      default: thr = CUR_W'($urandom_range(0, 400));
    endcase
    case ($urandom_range(0, 5))
      0:       intv = '1;
      1:       intv = MS_W'($urandom);
      default: intv = MS_W'($urandom_range(0, 20));
    endcase
    cluster_base = SAMPLE_W'($urandom);
    apply_settings(wl, gain, thr, intv);
  endtask

  // A quarter ticks; samples either anywhere or in a narrow band so that
  // small peak-to-peak values land near the 2 mA floor and the threshold.
  task automatic random_request();
    req_kind_t           kind;
    logic [SAMPLE_W-1:0] smp;
    kind = ($urandom_range(0, 99) < 25) ? REQ_TICK : REQ_SAMPLE;
    if ($urandom_range(0, 1) == 0) smp = SAMPLE_W'($urandom);
    else smp = cluster_base + SAMPLE_W'($urandom_range(0, 63));
    send_request(kind, smp);
  endtask

  // Register extremes, rounding, floor and saturation, ms counter stuck at
  // all ones, window shortened under a running count.
  task automatic test_directed_cases();
    // zero window acts as one; threshold 0 alerts on a 0 reading; a tick
    // right after reset must leave the counter saturated so the first
    // alert still toggles against the longest interval
    apply_settings('0, GAIN_RST, '0, '1);
    send_request(REQ_TICK, '1);
    send_request(REQ_SAMPLE, '0);
    send_request(REQ_SAMPLE, '1);
    // two-sample windows, interval zero toggles on every alert window,
    // alert clear, reading 19 squelched, reading 20 kept
    apply_settings(11'd2, GAIN_RST, THRESH_RST, '0);
    send_request(REQ_SAMPLE, '0);
    send_request(REQ_SAMPLE, '1);
    send_request(REQ_SAMPLE, 12'd100);
    send_request(REQ_SAMPLE, 12'd100);
    send_request(REQ_SAMPLE, 12'd10);
    send_request(REQ_SAMPLE, 12'd29);
    send_request(REQ_TICK, 12'hABC);
    send_request(REQ_SAMPLE, 12'd10);
    send_request(REQ_SAMPLE, 12'd30);
    // largest gain saturates; alert at threshold equality
    apply_settings(11'd2, '1, '1, '0);
    send_request(REQ_SAMPLE, '0);
    send_request(REQ_SAMPLE, '1);
    // half gain: 20.5 rounds to 21, 19.5 rounds to 20
    apply_settings(11'd2, 24'd32768, 16'd21, '0);
    send_request(REQ_SAMPLE, 12'd0);
    send_request(REQ_SAMPLE, 12'd41);
    send_request(REQ_SAMPLE, 12'd100);
    send_request(REQ_SAMPLE, 12'd139);
    // zero gain reads zero
    apply_settings(11'd2, '0, '0, '0);
    send_request(REQ_SAMPLE, '1);
    send_request(REQ_SAMPLE, '0);
    // window cut from 8 to 2 with 3 samples in: next sample closes it
    apply_settings(11'd8, GAIN_RST, THRESH_RST, 16'd1);
    send_request(REQ_SAMPLE, 12'd5);
    send_request(REQ_SAMPLE, 12'd6);
    send_request(REQ_SAMPLE, 12'd7);
    apply_settings(11'd2, GAIN_RST, THRESH_RST, 16'd1);
    send_request(REQ_SAMPLE, 12'd4000);
  endtask

  // Three idle patterns, six settings each, 12 requests per setting
  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct <= 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct <= 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int blk = 0; blk < 6; blk++) begin
        random_settings();
        repeat (12) random_request();
      end
    end
  endtask

  // Receiver goes quiet for a long stretch while requests keep coming; the
  // block must fill up, drop in_ready and lose nothing.
  task automatic test_output_backpressure();
    apply_settings(11'd3, GAIN_RST, 16'd100, 16'd2);
    -> hold_off_trig;
    repeat (40) random_request();
  endtask

  // Long window at the reset length; only its last sample may close it.
  task automatic test_long_window();
    apply_settings(WLEN_W'(LONG_WIN), GAIN_RST, 16'd4095, '0);
    for (int i = 0; i < LONG_WIN; i++) begin
      if (i == 0) send_request(REQ_SAMPLE, '0);
      else if (i == LONG_WIN - 1) send_request(REQ_SAMPLE, '1);
      else send_request(REQ_SAMPLE, SAMPLE_W'($urandom_range(1, 4094)));
    end
    send_request(REQ_TICK, '0);
    send_request(REQ_SAMPLE, 12'd77);
  endtask

  // Receiver: random stalls at the current rate, or a forced hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_active) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Long hold-off, counted here so the sender keeps running meanwhile
  always begin
    @(hold_off_trig);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Every accepted result is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    reading_t want;
    reading_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_measurement_done, out_current_tenth_ma, out_alert,
               out_relay_open, out_led_on, out_buzzer_on};
      if (expected_readings.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %p",
                 $time, seen);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("measurement_done", 32'(want.done), 32'(seen.done));
        check_field("current_tenth_ma", 32'(want.current), 32'(seen.current));
        check_field("alert", 32'(want.alert), 32'(seen.alert));
        check_field("relay_open", 32'(want.relay), 32'(seen.relay));
        check_field("led_on", 32'(want.led), 32'(seen.led));
        check_field("buzzer_on", 32'(want.buzzer), 32'(seen.buzzer));
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_readings.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic();
    test_output_backpressure();
    test_long_window();
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
